>>> rtl/page_table_walker_core_defines.svh
// ---------------------------------------------------------------------------
// Page table walker assertion macros
// Shared concurrent assertion forms for the walker RTL.
// ---------------------------------------------------------------------------
`ifndef PAGE_TABLE_WALKER_CORE_DEFINES_SVH
`define PAGE_TABLE_WALKER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PTW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ptw_pkg.sv
// ---------------------------------------------------------------------------
// ptw_pkg
// Types, codes and constants shared by the page table walker modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

	localparam int VA_W   = 48;
	localparam int PA_W   = 63;
	localparam int PTE_W  = 64;
	localparam int KIND_W = 2;
	localparam int PM_W   = 2;
	localparam int LVL_W  = 3;
	localparam int SH_W   = 6;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register index (paddr word index)
	localparam logic [0:0] REG_PAGING_MODE = 1'b0;

	// paging modes
	localparam logic [PM_W-1:0] PM_TWO_LEVEL = 2'd0;
	localparam logic [PM_W-1:0] PM_PAE       = 2'd1;
	localparam logic [PM_W-1:0] PM_LONG      = 2'd2;

	// input word kinds
	localparam logic MODE_REQUEST = 1'b0;
	localparam logic MODE_ENTRY   = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FAULT = 2'd2;

	// PTE bits
	localparam int PTE_PRESENT = 0;
	localparam int PTE_HUGE    = 7;

	// top-level index masks and their low bit positions
	localparam logic [VA_W-1:0] MASK_TOP_LONG = 48'h0000_ff80_0000_0000;
	localparam logic [VA_W-1:0] MASK_TOP_PAE  = 48'h0000_007f_c000_0000;
	localparam logic [VA_W-1:0] MASK_TOP_TWO  = 48'h0000_0000_ffc0_0000;
	localparam logic [SH_W-1:0] SHIFT_TOP_LONG = 6'd39;
	localparam logic [SH_W-1:0] SHIFT_TOP_PAE  = 6'd30;
	localparam logic [SH_W-1:0] SHIFT_TOP_TWO  = 6'd22;

	localparam logic [PA_W-1:0] BASE_MASK_PAE   = 63'h0000_0000_ffff_ffe0;
	localparam logic [PA_W-1:0] BASE_MASK_OTHER = 63'h7fff_ffff_ffff_f000;

	typedef struct packed {
		logic              mode;
		logic [VA_W-1:0]   virt_addr;
		logic [PA_W-1:0]   directory_base;
		logic [PTE_W-1:0]  entry_data;
	} ptw_req_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [PA_W-1:0]   address;
		logic              entry_is_wide;
	} ptw_rsp_t;

	// walk context; shift is the low bit position of mask (0 once it is gone)
	typedef struct packed {
		logic              active;
		logic [LVL_W-1:0]  level;
		logic [VA_W-1:0]   mask;
		logic [SH_W-1:0]   shift;
		logic [VA_W-1:0]   vaddr;
	} ptw_walk_t;

endpackage

`default_nettype wire

>>> rtl/ptw_apb.sv
// ---------------------------------------------------------------------------
// ptw_apb
// APB register slave holding the paging mode.
// ---------------------------------------------------------------------------
`default_nettype none

module ptw_apb (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ptw_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ptw_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ptw_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output logic [ptw_pkg::PM_W-1:0]         paging_mode
);
	import ptw_pkg::*;

	logic [0:0]      reg_idx;
	logic            wr_en;
	logic [PM_W-1:0] paging_mode_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_mode_q <= PM_TWO_LEVEL;
		end else if (wr_en && reg_idx == REG_PAGING_MODE) begin
			paging_mode_q <= pwdata[PM_W-1:0];
		end
	end

	assign paging_mode = paging_mode_q;
	assign prdata = (reg_idx == REG_PAGING_MODE) ?
		{{(APB_DATA_W-PM_W){1'b0}}, paging_mode_q} : '0;

endmodule

`default_nettype wire

>>> rtl/ptw_step.sv
// ---------------------------------------------------------------------------
// ptw_step
// One walk step: start a walk or consume a returned entry.
// ---------------------------------------------------------------------------
`default_nettype none

module ptw_step (
	input  ptw_pkg::ptw_walk_t        walk,
	input  ptw_pkg::ptw_req_t         word,
	input  logic [ptw_pkg::PM_W-1:0]  paging_mode,
	output ptw_pkg::ptw_walk_t        walk_next,
	output logic                      has_result,
	output ptw_pkg::ptw_rsp_t         result
);
	import ptw_pkg::*;

	logic             is_long, is_pae, is_two, is_req;

	logic [VA_W-1:0]  new_vaddr, new_mask;
	logic [SH_W-1:0]  new_shift;
	logic [LVL_W-1:0] new_level;
	logic [PA_W-1:0]  new_base;

	logic [PTE_W-1:0] pte;
	logic [PA_W-1:0]  frame;
	logic [VA_W-1:0]  below;
	logic             huge;
	logic [VA_W-1:0]  step_mask;
	logic [SH_W-1:0]  step_amt, step_shift;
	logic [LVL_W-1:0] step_level;
	logic             last;

	logic [VA_W-1:0]  rd_vaddr, rd_mask, idx;
	logic [SH_W-1:0]  rd_shift;
	logic [PA_W-1:0]  rd_base, idx_ext, rd_addr;

	assign is_long = paging_mode == PM_LONG;
	assign is_pae  = paging_mode == PM_PAE;
	assign is_two  = !is_long && !is_pae;
	assign is_req  = word.mode == MODE_REQUEST;

	// new walk context
	assign new_vaddr = is_long ? word.virt_addr :
		{{(VA_W-32){1'b0}}, word.virt_addr[31:0]};
	assign new_mask  = is_long ? MASK_TOP_LONG : (is_pae ? MASK_TOP_PAE : MASK_TOP_TWO);
	assign new_shift = is_long ? SHIFT_TOP_LONG : (is_pae ? SHIFT_TOP_PAE : SHIFT_TOP_TWO);
	assign new_level = is_long ? 3'd4 : (is_pae ? 3'd3 : 3'd2);
	assign new_base  = word.directory_base & (is_pae ? BASE_MASK_PAE : BASE_MASK_OTHER);

	// returned entry
	assign pte   = is_two ? {32'b0, word.entry_data[31:0]} : word.entry_data;
	assign frame = {{(PA_W-VA_W){1'b0}}, pte[47:12], 12'b0};
	assign below = (48'd1 << walk.shift) - 48'd1;
	assign huge  = pte[PTE_HUGE] &&
		(walk.level == 3'd2 || (walk.level == 3'd3 && is_long));

	assign step_amt   = is_two ? 6'd10 : 6'd9;
	assign step_mask  = walk.mask >> step_amt;
	// mask stays contiguous, so its low bit just slides down and clamps at zero
	assign step_shift = (walk.shift >= step_amt) ? walk.shift - step_amt : '0;
	assign step_level = walk.level - 3'd1;
	assign last       = step_level == 3'd0 || step_level > 3'd4;

	// one entry-address generator shared by both paths
	assign rd_vaddr = is_req ? new_vaddr : walk.vaddr;
	assign rd_mask  = is_req ? new_mask  : step_mask;
	assign rd_shift = is_req ? new_shift : step_shift;
	assign rd_base  = is_req ? new_base  : frame;
	assign idx      = (rd_vaddr & rd_mask) >> rd_shift;
	assign idx_ext  = {{(PA_W-VA_W){1'b0}}, idx};
	assign rd_addr  = rd_base + (is_two ? (idx_ext << 2) : (idx_ext << 3));

	always_comb begin
		walk_next  = walk;
		has_result = 1'b0;
		result     = '0;
		if (is_req) begin
			walk_next.active     = 1'b1;
			walk_next.level      = new_level;
			walk_next.mask       = new_mask;
			walk_next.shift      = new_shift;
			walk_next.vaddr      = new_vaddr;
			has_result           = 1'b1;
			result.result_kind   = KIND_READ;
			result.address       = rd_addr;
			result.entry_is_wide = !is_two;
		end else if (walk.active) begin
			has_result = 1'b1;
			if (!pte[PTE_PRESENT]) begin
				walk_next.active   = 1'b0;
				result.result_kind = KIND_FAULT;
				result.address     = {{(PA_W-VA_W){1'b0}}, walk.vaddr};
			end else if (huge) begin
				walk_next.active   = 1'b0;
				result.result_kind = KIND_DONE;
				result.address     = (frame & ~{{(PA_W-VA_W){1'b0}}, below}) |
					{{(PA_W-VA_W){1'b0}}, walk.vaddr & below};
			end else begin
				walk_next.mask  = step_mask;
				walk_next.shift = step_shift;
				walk_next.level = step_level;
				if (last) begin
					walk_next.active   = 1'b0;
					walk_next.level    = '0;
					result.result_kind = KIND_DONE;
					result.address     = frame | {{(PA_W-12){1'b0}}, walk.vaddr[11:0]};
				end else begin
					result.result_kind   = KIND_READ;
					result.address       = rd_addr;
					result.entry_is_wide = !is_two;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/page_table_walker_core.sv
// ---------------------------------------------------------------------------
// page_table_walker_core
// x86 page table walker: two-level, PAE and long mode, one step per word.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_word): a word is either a translate
//   request (mode 0: virtual address + directory base) or a page table entry
//   returned from memory (mode 1). rsp channel (rsp_valid/rsp_ready/rsp_word)
//   carries entry read requests, the final physical address, or a fault.
//   The caller reads the entry named by each read request and feeds it back.
//   An entry word with no walk in progress is dropped and gives no response.
//   A request mid-walk abandons the old walk.
// Timing:
//   rsp_valid rises once a word has passed the input stage and the single step
//   unit has written the response register. Throughput is one word per cycle
//   while rsp is not stalled; the walk context updates in the same cycle as
//   the step, so the next word sees it.
// Stalls: with rsp_valid high and rsp_ready low the response register holds,
//   the input stage holds its word, and req_ready falls once that stage is full.
// Reset: arst_n clears the walk (idle), both valid flags and paging_mode
//   (two-level). No clearing pass is needed.
// Config: paging_mode at APB byte address 0; users must write it only while idle (unenforced).
// ---------------------------------------------------------------------------
`default_nettype none
`include "page_table_walker_core_defines.svh"

module page_table_walker_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  ptw_pkg::ptw_req_t                req_word,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output ptw_pkg::ptw_rsp_t                rsp_word,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ptw_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ptw_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ptw_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import ptw_pkg::*;

	logic            req_valid_s1;
	ptw_req_t        req_s1;
	ptw_walk_t       walk_q, walk_next;
	logic            rsp_valid_q;
	ptw_rsp_t        rsp_word_q;
	logic [PM_W-1:0] paging_mode;
	logic            has_result;
	ptw_rsp_t        step_rsp;
	logic            advance;   // response register free (or draining)
	logic            fire;      // stage 1 word is processed this cycle

	ptw_apb u_apb (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.paging_mode (paging_mode)
	);

	ptw_step u_step (
		.walk        (walk_q),
		.word        (req_s1),
		.paging_mode (paging_mode),
		.walk_next   (walk_next),
		.has_result  (has_result),
		.result      (step_rsp)
	);

	assign advance   = !rsp_valid_q || rsp_ready;
	assign fire      = req_valid_s1 && advance;
	assign req_ready = !req_valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req_word;
		end
	end

	// walk context follows every processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (fire) begin
			walk_q <= walk_next;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= req_valid_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			rsp_word_q <= step_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	`PTW_ASSERT_NEXT(a_stage_holds, clk, arst_n,
		req_valid_s1 && rsp_valid_q && !rsp_ready, req_valid_s1, "stage 1 word lost in stall")
	`PTW_ASSERT_NEXT(a_idle_entry_silent, clk, arst_n,
		fire && req_s1.mode == MODE_ENTRY && !walk_q.active, !rsp_valid_q,
		"entry with no walk produced a response")
	`PTW_ASSERT_NEXT(a_read_keeps_walk, clk, arst_n,
		fire && has_result && step_rsp.result_kind == KIND_READ, walk_q.active,
		"read request issued without active walk")
	`PTW_ASSERT_NEXT(a_end_stops_walk, clk, arst_n,
		fire && has_result && step_rsp.result_kind != KIND_READ, !walk_q.active,
		"walk still active after done or fault")
	`PTW_ASSERT_NOW(a_wide_only_on_read, clk, arst_n,
		rsp_valid_q && rsp_word_q.result_kind != KIND_READ, !rsp_word_q.entry_is_wide,
		"wide flag set on a final response")

endmodule

`default_nettype wire
